// ===== design/indexed_doubly_linked_list_assert.svh =====
// Assertion helpers for the linked-list block.
// Both expect signals named clock and reset in the including scope.
`ifndef INDEXED_DOUBLY_LINKED_LIST_ASSERT_SVH
`define INDEXED_DOUBLY_LINKED_LIST_ASSERT_SVH

// Same-cycle implication.
`define IDLL_ASSERT_IMP(name, cond, conseq) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error("linked list assertion failed");

// Next-cycle implication.
`define IDLL_ASSERT_NEXT(name, cond, conseq) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error("linked list assertion failed");

`endif

// ===== design/idll_pkg.sv =====
package idll_pkg;

   // Highest usable entry number (2 to 63); entry 0 means no neighbor.
   localparam int ENTRIES = 63;
   localparam int ID_W    = 6;
   localparam int DEPTH   = 1 << ID_W;

   typedef logic [ID_W-1:0] id_type;

   typedef enum logic [1:0] {
      OP_INS_LEFT  = 2'd0,
      OP_INS_RIGHT = 2'd1,
      OP_REMOVE    = 2'd2,
      OP_WALK      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      RS_DONE   = 3'd0,
      RS_ABSENT = 3'd1,
      RS_REJECT = 3'd2,
      RS_LISTED = 3'd3,
      RS_EMPTY  = 3'd4
   } rsp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_W1,
      ST_INS_W2,
      ST_RM_W1,
      ST_RM_W2,
      ST_WALK,
      ST_RESP
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic           load_req;
      logic           rd_anchor;
      logic           rd_item;
      logic           walk_start;
      logic           walk_step;
      logic           ins_w1;
      logic           ins_w2;
      logic           rm_w1;
      logic           rm_w2;
      logic           status_we;
      rsp_status_type status;
      logic           emit_status;
   } ctl_type;

   // Datapath to controller status.
   typedef struct packed {
      op_type op;
      logic   ins_ok;
      logic   rm_ok;
      logic   head_zero;
      logic   out_free;
      logic   walk_last;
   } flg_type;

   // One link table port request.
   typedef struct packed {
      logic   rd_en;
      id_type rd_addr;
      logic   wr_en;
      id_type wr_addr;
      id_type wr_data;
   } ram_req_type;

   function automatic logic valid_id(id_type id);
      return (id != '0) && (id <= ID_W'(ENTRIES));
   endfunction

endpackage

// ===== design/idll_link_ram.sv =====
module idll_link_ram (
   input  logic                     clock,
   input  logic                     reset,
   input  idll_pkg::ram_req_type    req,
   output idll_pkg::id_type         rd_data
);

   idll_pkg::id_type                   link_mem_ff [idll_pkg::DEPTH];
   logic [idll_pkg::DEPTH-1:0]         vld_ff;
   logic [idll_pkg::DEPTH-1:0]         vld_in;
   idll_pkg::id_type                   rd_data_ff;

   always_comb begin
      vld_in = vld_ff;
      if (req.wr_en) begin
         vld_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         link_mem_ff[req.wr_addr] <= req.wr_data;
      end
   end

   // Never-written entries read as no neighbor.
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= vld_ff[req.rd_addr] ? link_mem_ff[req.rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/idll_datapath.sv =====
module idll_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  idll_pkg::ctl_type           ctl,
   output idll_pkg::flg_type           flg,
   input  logic [1:0]                  req_cmd,
   input  idll_pkg::id_type            req_item_id,
   input  idll_pkg::id_type            req_anchor_id,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output idll_pkg::rsp_status_type    rsp_status,
   output idll_pkg::id_type            rsp_entry_id,
   output logic                        rsp_last
);

   idll_pkg::op_type                op_ff;
   idll_pkg::id_type                item_ff;
   idll_pkg::id_type                anchor_ff;
   logic [idll_pkg::DEPTH-1:0]      present_ff;
   logic [idll_pkg::DEPTH-1:0]      present_in;
   idll_pkg::id_type                head_ff;
   idll_pkg::id_type                head_in;
   idll_pkg::id_type                cur_ff;
   idll_pkg::id_type                cnt_ff;
   idll_pkg::rsp_status_type        status_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   idll_pkg::rsp_status_type        rsp_status_ff;
   idll_pkg::id_type                rsp_entry_ff;
   logic                            rsp_last_ff;

   idll_pkg::ram_req_type           next_req;
   idll_pkg::ram_req_type           prev_req;
   idll_pkg::id_type                next_rd;
   idll_pkg::id_type                prev_rd;

   logic                            near_is_next;
   idll_pkg::id_type                near_rd;
   logic                            walk_last;
   logic                            out_free;

   idll_link_ram u_next (
      .clock   (clock),
      .reset   (reset),
      .req     (next_req),
      .rd_data (next_rd)
   );

   idll_link_ram u_prev (
      .clock   (clock),
      .reset   (reset),
      .req     (prev_req),
      .rd_data (prev_rd)
   );

   // Right insert walks the next table from the anchor, left insert the prev table.
   assign near_is_next = (op_ff == idll_pkg::OP_INS_RIGHT);
   assign near_rd      = near_is_next ? next_rd : prev_rd;
   assign walk_last    = (next_rd == '0) || (cnt_ff == idll_pkg::ID_W'(idll_pkg::ENTRIES - 1));
   assign out_free     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      flg.op        = op_ff;
      flg.ins_ok    = idll_pkg::valid_id(item_ff) && idll_pkg::valid_id(anchor_ff)
                      && present_ff[anchor_ff] && !present_ff[item_ff];
      flg.rm_ok     = idll_pkg::valid_id(item_ff) && present_ff[item_ff];
      flg.head_zero = (head_ff == '0);
      flg.out_free  = out_free;
      flg.walk_last = walk_last;
   end

   // Link table requests.
   always_comb begin
      next_req = '0;
      prev_req = '0;

      if (ctl.rd_anchor) begin
         next_req.rd_en   = near_is_next;
         next_req.rd_addr = anchor_ff;
         prev_req.rd_en   = !near_is_next;
         prev_req.rd_addr = anchor_ff;
      end
      if (ctl.rd_item) begin
         next_req.rd_en   = 1'b1;
         next_req.rd_addr = item_ff;
         prev_req.rd_en   = 1'b1;
         prev_req.rd_addr = item_ff;
      end
      if (ctl.walk_start) begin
         next_req.rd_en   = 1'b1;
         next_req.rd_addr = head_ff;
      end
      if (ctl.walk_step) begin
         next_req.rd_en   = 1'b1;
         next_req.rd_addr = next_rd;
      end

      // Splice the far neighbor to the new entry, point the new entry at it.
      if (ctl.ins_w1) begin
         if (near_is_next) begin
            next_req.wr_en   = 1'b1;
            next_req.wr_addr = item_ff;
            next_req.wr_data = near_rd;
            prev_req.wr_en   = (near_rd != '0);
            prev_req.wr_addr = near_rd;
            prev_req.wr_data = item_ff;
         end else begin
            prev_req.wr_en   = 1'b1;
            prev_req.wr_addr = item_ff;
            prev_req.wr_data = near_rd;
            next_req.wr_en   = (near_rd != '0);
            next_req.wr_addr = near_rd;
            next_req.wr_data = item_ff;
         end
      end
      // Join anchor and new entry.
      if (ctl.ins_w2) begin
         if (near_is_next) begin
            next_req.wr_en   = 1'b1;
            next_req.wr_addr = anchor_ff;
            next_req.wr_data = item_ff;
            prev_req.wr_en   = 1'b1;
            prev_req.wr_addr = item_ff;
            prev_req.wr_data = anchor_ff;
         end else begin
            prev_req.wr_en   = 1'b1;
            prev_req.wr_addr = anchor_ff;
            prev_req.wr_data = item_ff;
            next_req.wr_en   = 1'b1;
            next_req.wr_addr = item_ff;
            next_req.wr_data = anchor_ff;
         end
      end
      // Bridge over the removed entry.
      if (ctl.rm_w1) begin
         next_req.wr_en   = (prev_rd != '0);
         next_req.wr_addr = prev_rd;
         next_req.wr_data = next_rd;
         prev_req.wr_en   = (next_rd != '0);
         prev_req.wr_addr = next_rd;
         prev_req.wr_data = prev_rd;
      end
      // Clear the removed entry's links.
      if (ctl.rm_w2) begin
         next_req.wr_en   = 1'b1;
         next_req.wr_addr = item_ff;
         next_req.wr_data = '0;
         prev_req.wr_en   = 1'b1;
         prev_req.wr_addr = item_ff;
         prev_req.wr_data = '0;
      end
   end

   always_comb begin
      head_in    = head_ff;
      present_in = present_ff;
      if (ctl.ins_w1 && !near_is_next && (near_rd == '0)) begin
         head_in = item_ff;
      end
      if (ctl.rm_w1 && (prev_rd == '0)) begin
         head_in = next_rd;
      end
      if (ctl.ins_w2) begin
         present_in[item_ff] = 1'b1;
      end
      if (ctl.rm_w2) begin
         present_in[item_ff] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctl.walk_step || ctl.emit_status) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= idll_pkg::ID_W'(1);
         present_ff   <= idll_pkg::DEPTH'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         op_ff     <= idll_pkg::op_type'(req_cmd);
         item_ff   <= req_item_id;
         anchor_ff <= req_anchor_id;
      end
      if (ctl.status_we) begin
         status_ff <= ctl.status;
      end
      if (ctl.walk_start) begin
         cur_ff <= head_ff;
         cnt_ff <= '0;
      end else if (ctl.walk_step) begin
         cur_ff <= next_rd;
         cnt_ff <= cnt_ff + idll_pkg::ID_W'(1);
      end
      if (ctl.walk_step) begin
         rsp_status_ff <= idll_pkg::RS_LISTED;
         rsp_entry_ff  <= cur_ff;
         rsp_last_ff   <= walk_last;
      end else if (ctl.emit_status) begin
         rsp_status_ff <= status_ff;
         rsp_entry_ff  <= '0;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_entry_id = rsp_entry_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== design/idll_ctrl.sv =====
module idll_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  idll_pkg::flg_type     flg,
   output idll_pkg::ctl_type     ctl
);

   idll_pkg::state_type state_ff;
   idll_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idll_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         idll_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = idll_pkg::ST_DECODE;
            end
         end
         idll_pkg::ST_DECODE: begin
            case (flg.op)
               idll_pkg::OP_INS_LEFT, idll_pkg::OP_INS_RIGHT: begin
                  state_in = flg.ins_ok ? idll_pkg::ST_INS_W1 : idll_pkg::ST_RESP;
               end
               idll_pkg::OP_REMOVE: begin
                  state_in = flg.rm_ok ? idll_pkg::ST_RM_W1 : idll_pkg::ST_RESP;
               end
               default: begin
                  state_in = flg.head_zero ? idll_pkg::ST_RESP : idll_pkg::ST_WALK;
               end
            endcase
         end
         idll_pkg::ST_INS_W1: state_in = idll_pkg::ST_INS_W2;
         idll_pkg::ST_INS_W2: state_in = idll_pkg::ST_RESP;
         idll_pkg::ST_RM_W1:  state_in = idll_pkg::ST_RM_W2;
         idll_pkg::ST_RM_W2:  state_in = idll_pkg::ST_RESP;
         idll_pkg::ST_WALK: begin
            if (flg.out_free && flg.walk_last) begin
               state_in = idll_pkg::ST_IDLE;
            end
         end
         idll_pkg::ST_RESP: begin
            if (flg.out_free) begin
               state_in = idll_pkg::ST_IDLE;
            end
         end
         default: state_in = idll_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl        = '0;
      ctl.status = idll_pkg::RS_DONE;
      req_ready  = 1'b0;
      case (state_ff)
         idll_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            ctl.load_req = req_valid;
         end
         idll_pkg::ST_DECODE: begin
            case (flg.op)
               idll_pkg::OP_INS_LEFT, idll_pkg::OP_INS_RIGHT: begin
                  ctl.rd_anchor = flg.ins_ok;
                  ctl.status_we = !flg.ins_ok;
                  ctl.status    = idll_pkg::RS_REJECT;
               end
               idll_pkg::OP_REMOVE: begin
                  ctl.rd_item   = flg.rm_ok;
                  ctl.status_we = !flg.rm_ok;
                  ctl.status    = idll_pkg::RS_ABSENT;
               end
               default: begin
                  ctl.walk_start = !flg.head_zero;
                  ctl.status_we  = flg.head_zero;
                  ctl.status     = idll_pkg::RS_EMPTY;
               end
            endcase
         end
         idll_pkg::ST_INS_W1: ctl.ins_w1 = 1'b1;
         idll_pkg::ST_INS_W2: begin
            ctl.ins_w2    = 1'b1;
            ctl.status_we = 1'b1;
            ctl.status    = idll_pkg::RS_DONE;
         end
         idll_pkg::ST_RM_W1: ctl.rm_w1 = 1'b1;
         idll_pkg::ST_RM_W2: begin
            ctl.rm_w2     = 1'b1;
            ctl.status_we = 1'b1;
            ctl.status    = idll_pkg::RS_DONE;
         end
         idll_pkg::ST_WALK: ctl.walk_step = flg.out_free;
         idll_pkg::ST_RESP: ctl.emit_status = flg.out_free;
         default: ctl = '0;
      endcase
   end

endmodule

// ===== design/indexed_doubly_linked_list.sv =====
// Ordered list of entries 1..63 kept in next-link and prev-link tables, a presence
// map and a head pointer; after reset the list holds entry 1 alone. One item is
// handled at a time. An insert or remove that goes ahead passes through decode
// together with the link-table read, two write steps since each table has one
// write port, then the result hand-off. A rejected or ignored one, like a walk
// of an empty list, goes from decode straight to the result hand-off. A walk
// reads the head entry in decode, then presents one result each cycle while the
// result register is free, the next-link read of each entry addressing the read
// of the one after it. A new item is accepted the cycle after the last result has
// been handed to the result register, even if that result is still waiting to be
// taken.
`include "indexed_doubly_linked_list_assert.svh"

module indexed_doubly_linked_list (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cmd[1:0], item_id[7:2], anchor_id[13:8], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[2:0], entry_id[8:3], zero
   output logic        rsp_tlast
);

   idll_pkg::ctl_type           ctl;
   idll_pkg::flg_type           flg;
   idll_pkg::rsp_status_type    rsp_status;
   idll_pkg::id_type            rsp_entry_id;
   logic [4:0]                  step_vec;
   logic                        status_rsp;

   idll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .flg       (flg),
      .ctl       (ctl)
   );

   idll_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .flg           (flg),
      .req_cmd       (req_tdata[1:0]),
      .req_item_id   (req_tdata[7:2]),
      .req_anchor_id (req_tdata[13:8]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_status    (rsp_status),
      .rsp_entry_id  (rsp_entry_id),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, rsp_entry_id, rsp_status};

   assign step_vec = {ctl.ins_w1, ctl.ins_w2, ctl.rm_w1, ctl.rm_w2, ctl.walk_step};

   assign status_rsp = rsp_tvalid && (rsp_status != idll_pkg::RS_LISTED);

   `IDLL_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `IDLL_ASSERT_IMP(a_one_step, 1'b1, $onehot0(step_vec))
   `IDLL_ASSERT_IMP(a_status_shape, status_rsp, rsp_tlast && (rsp_entry_id == '0))

endmodule
